@@ rtl/pnc_pkg.sv @@
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared types and constants for the perfect number classifier.
// ----------------------------------------------------------------------------
package pnc_pkg;

    // Default width of the signed input word
    localparam int NUMBER_WIDTH_DEF = 16;

    // Extra sum bits above the number width; the aliquot sum stays below 16x
    localparam int SUM_EXTRA = 4;

    // Result class codes
    localparam logic [1:0] CLASS_INVALID   = 2'd0;
    localparam logic [1:0] CLASS_PERFECT   = 2'd1;
    localparam logic [1:0] CLASS_DEFICIENT = 2'd2;
    localparam logic [1:0] CLASS_ABUNDANT  = 2'd3;

    // Status returned by the shared divider
    typedef struct packed {
        logic done;      // one-cycle pulse, remainder is final
        logic rem_zero;  // divisor divides the dividend evenly
    } t_div_status;

endpackage

@@ rtl/perfect_number_classifier.sv @@
// ----------------------------------------------------------------------------
// perfect_number_classifier
// Classifies a signed integer by its aliquot sum: invalid, perfect,
// deficient or abundant.
// ----------------------------------------------------------------------------
// A non-positive number gives its word in the cycle after start; for a positive
// number n each candidate 1..n-1 runs in turn through the shared bit-serial
// divider, the sequencer passing its check and wait states for every candidate.
// One number at a time; for a positive one, busy stays high until its class is out.
// Reset (synchronous, active low) returns to idle and drops any pending word.
// The receiver cannot stall: o_done marks the class for exactly one cycle.
// ----------------------------------------------------------------------------
module perfect_number_classifier
    import pnc_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    output logic                    o_done,
    output logic [1:0]              o_number_class
);

    localparam int SW = NUMBER_WIDTH + SUM_EXTRA;

    // Sequencer state codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    logic [1:0]              r_state;
    logic [NUMBER_WIDTH-1:0] r_num;     // number under test
    logic [NUMBER_WIDTH-1:0] r_cand;    // candidate divisor
    logic [SW-1:0]           r_sum;     // running aliquot sum
    logic                    r_done;
    logic [1:0]              r_class;

    logic                    accept;
    logic                    last_cand;
    logic                    div_go;
    logic [SW-1:0]           num_ext;
    t_div_status             div_stat;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign last_cand = (r_cand == r_num);
    assign div_go    = (r_state == S_CHECK) && !last_cand;
    assign num_ext   = SW'(r_num);

    // Shared divider: remainder of the number by the current candidate
    pnc_divider #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (r_num),
        .i_divisor  (r_cand),
        .o_status   (div_stat)
    );

    // Sequencer: launch a division per candidate, collect, then classify
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // Non-positive: answer at once, keep idle
                        if (i_number[NUMBER_WIDTH-1] || i_number == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    // Candidates exhausted: emit the class word
                    if (last_cand) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (div_stat.done) begin
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: hold the number, advance the candidate, accumulate the sum
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_num   <= i_number;
            r_cand  <= NUMBER_WIDTH'(1);
            r_sum   <= '0;
            r_class <= CLASS_INVALID;
        end else if (r_state == S_WAIT && div_stat.done) begin
            r_cand <= r_cand + NUMBER_WIDTH'(1);
            if (div_stat.rem_zero) begin
                r_sum <= r_sum + SW'(r_cand);
            end
        end else if (r_state == S_CHECK && last_cand) begin
            if (r_sum == num_ext) begin
                r_class <= CLASS_PERFECT;
            end else if (r_sum < num_ext) begin
                r_class <= CLASS_DEFICIENT;
            end else begin
                r_class <= CLASS_ABUNDANT;
            end
        end
    end

    assign o_done         = r_done;
    assign o_number_class = r_class;

endmodule

@@ rtl/pnc_divider.sv @@
// ----------------------------------------------------------------------------
// pnc_divider
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pnc_divider
    import pnc_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_go,
    input  logic [NUMBER_WIDTH-1:0] i_dividend,
    input  logic [NUMBER_WIDTH-1:0] i_divisor,
    output t_div_status             o_status
);

    localparam int CW = $clog2(NUMBER_WIDTH + 1);

    logic [NUMBER_WIDTH-1:0] r_rem, n_rem;
    logic [NUMBER_WIDTH-1:0] r_quo, n_quo;
    logic [NUMBER_WIDTH-1:0] r_dsr;
    logic [CW-1:0]           r_cnt;
    logic                    r_run;
    logic                    r_done;
    logic [NUMBER_WIDTH:0]   trial;
    logic [NUMBER_WIDTH:0]   diff;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_quo[NUMBER_WIDTH-1]};
        diff  = trial - {1'b0, r_dsr};
        if (!diff[NUMBER_WIDTH]) begin
            n_rem = diff[NUMBER_WIDTH-1:0];
        end else begin
            n_rem = trial[NUMBER_WIDTH-1:0];
        end
        n_quo = {r_quo[NUMBER_WIDTH-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= CW'(NUMBER_WIDTH);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule
